// ===== src/rrsfc_pkg.sv =====
// Shared types and constants for the receive ring sequence flow-control tracker.
package rrsfc_pkg;

  localparam int SEQ_W  = 32;
  localparam int SLOT_W = 6;
  localparam int NBUF_W = 7;

  // Largest ring the slot fields can address.
  localparam int RING_CAP = 64;
  localparam int MAX_BUFFERS_DEF = 64;

  localparam logic [NBUF_W-1:0] NBUF_RESET = NBUF_W'(16);

  localparam logic ACT_POLL = 1'b0;
  localparam logic ACT_FREE = 1'b1;

  // One ring slot as held in the slot memory.
  typedef struct packed {
    logic             owned;
    logic [SEQ_W-1:0] prev_seq;
    logic [SEQ_W-1:0] exp_seq;
  } slot_entry_t;

  // One result word.
  typedef struct packed {
    logic              new_message;
    logic [SLOT_W-1:0] result_slot;
    logic              sequence_error;
    logic              ownership_error;
    logic [SEQ_W-1:0]  freed_sequence;
    logic              request_signaled;
    logic              wait_completion;
  } result_t;

  // State updates produced by one word.
  typedef struct packed {
    logic              wr_en;
    slot_entry_t       wr_entry;
    logic              advance;
    logic [SLOT_W-1:0] next_slot;
    logic              pacing_upd;
    logic [NBUF_W-1:0] pacing_next;
  } update_t;

endpackage

// ===== src/rrsfc_in_if.sv =====
// Input channel carrying poll and free requests.
interface rrsfc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [rrsfc_pkg::SEQ_W-1:0]  header_sequence;
  logic [rrsfc_pkg::SLOT_W-1:0] free_slot;

  modport source (output valid, action, header_sequence, free_slot, input ready);
  modport sink   (input valid, action, header_sequence, free_slot, output ready);
endinterface

// ===== src/rrsfc_out_if.sv =====
// Output channel carrying one result word per request.
interface rrsfc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         new_message;
  logic [rrsfc_pkg::SLOT_W-1:0] result_slot;
  logic                         sequence_error;
  logic                         ownership_error;
  logic [rrsfc_pkg::SEQ_W-1:0]  freed_sequence;
  logic                         request_signaled;
  logic                         wait_completion;

  modport source (output valid, new_message, result_slot, sequence_error,
                  ownership_error, freed_sequence, request_signaled, wait_completion,
                  input ready);
  modport sink   (input valid, new_message, result_slot, sequence_error,
                  ownership_error, freed_sequence, request_signaled, wait_completion,
                  output ready);
endinterface

// ===== src/rrsfc_slot_mem.sv =====
// Slot memory with per-entry valid bits, registered read and write forwarding.
module rrsfc_slot_mem #(
  parameter int Depth = rrsfc_pkg::RING_CAP
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [rrsfc_pkg::SLOT_W-1:0] rd_slot_i,
  input  logic                         wr_en_i,
  input  logic [rrsfc_pkg::SLOT_W-1:0] wr_slot_i,
  input  rrsfc_pkg::slot_entry_t       wr_entry_i,
  output rrsfc_pkg::slot_entry_t       rd_entry_o
);
  import rrsfc_pkg::*;

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  slot_entry_t       mem [Depth];
  logic [Depth-1:0]  valid_q;

  slot_entry_t       rd_data_q;
  logic              rd_valid_q;
  logic              fwd_hit_q;
  slot_entry_t       fwd_q;
  logic [SLOT_W-1:0] rd_slot_q;
  slot_entry_t       reset_entry;

  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] wr_addr;

  assign rd_addr = rd_slot_i[AddrW-1:0];
  assign wr_addr = wr_slot_i[AddrW-1:0];

  // Memory write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr];
      fwd_q     <= wr_entry_i;
      rd_slot_q <= rd_slot_i;
    end
  end

  // Valid bits mark entries written since reset; the forward flag covers
  // a read that meets a write to the same slot at the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr];
        fwd_hit_q  <= wr_en_i && (wr_addr == rd_addr);
      end
    end
  end

  // An entry never written reads as its reset value.
  always_comb begin
    reset_entry          = '0;
    reset_entry.exp_seq  = SEQ_W'(rd_slot_q) + SEQ_W'(1);
    if (fwd_hit_q) begin
      rd_entry_o = fwd_q;
    end else if (rd_valid_q) begin
      rd_entry_o = rd_data_q;
    end else begin
      rd_entry_o = reset_entry;
    end
  end

endmodule

// ===== src/rrsfc_step.sv =====
// Decision logic for one poll or free word: result fields and state updates.
module rrsfc_step (
  input  logic                         action_i,
  input  logic [rrsfc_pkg::SEQ_W-1:0]  header_sequence_i,
  input  logic [rrsfc_pkg::SLOT_W-1:0] slot_i,
  input  rrsfc_pkg::slot_entry_t       entry_i,
  input  logic [rrsfc_pkg::NBUF_W-1:0] ring_len_i,
  input  logic [rrsfc_pkg::NBUF_W-1:0] pacing_i,
  output rrsfc_pkg::result_t           result_o,
  output rrsfc_pkg::update_t           update_o
);
  import rrsfc_pkg::*;

  logic              exp_match;
  logic              prev_match;
  logic              bad_free;
  logic              pace_wait;
  logic [NBUF_W-1:0] pace_base;
  logic [NBUF_W-1:0] slot_inc;

  assign exp_match  = (header_sequence_i == entry_i.exp_seq);
  assign prev_match = (header_sequence_i == entry_i.prev_seq);
  assign bad_free   = (NBUF_W'(slot_i) >= ring_len_i) || !entry_i.owned;
  assign pace_wait  = (pacing_i >= ring_len_i);
  assign pace_base  = pace_wait ? '0 : pacing_i;
  assign slot_inc   = NBUF_W'(slot_i) + NBUF_W'(1);

  always_comb begin
    result_o             = '0;
    result_o.result_slot = slot_i;
    update_o             = '0;
    update_o.wr_entry    = entry_i;
    update_o.next_slot   = (slot_inc >= ring_len_i) ? '0 : slot_inc[SLOT_W-1:0];
    update_o.pacing_next = pace_base + NBUF_W'(1);

    unique case (action_i)
      ACT_POLL: begin
        // A match hands the slot over and moves the ring on.
        result_o.new_message       = exp_match;
        result_o.sequence_error    = !exp_match && !prev_match;
        update_o.wr_en             = exp_match;
        update_o.advance           = exp_match;
        update_o.wr_entry.owned    = 1'b1;
      end
      ACT_FREE: begin
        // A good free returns the sequence and steps it by one ring length.
        result_o.ownership_error = bad_free;
        if (!bad_free) begin
          result_o.freed_sequence    = entry_i.exp_seq;
          result_o.wait_completion   = pace_wait;
          result_o.request_signaled  = (pace_base == '0);
          update_o.wr_en             = 1'b1;
          update_o.pacing_upd        = 1'b1;
          update_o.wr_entry.owned    = 1'b0;
          update_o.wr_entry.prev_seq = entry_i.exp_seq;
          update_o.wr_entry.exp_seq  = entry_i.exp_seq + SEQ_W'(ring_len_i);
        end
      end
      default: begin
        result_o.ownership_error = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/rx_ring_sequence_flow_control.sv =====
// Top level of the receive ring sequence flow-control tracker.
//
// Takes one poll or free word per clock while the output is not stalled and
// returns exactly one result word for each. Each word first reads the slot
// memory (one read and one write port, read data registered), then compares
// the header against the slot's expected and previous sequence numbers,
// updates the slot, ring pointer and pacing count, and loads the result
// register. A write and a read of the same slot at the same edge are
// forwarded. Slots read as their reset values until first written, so no
// clearing pass follows reset. The ring length comes from num_buffers,
// clamped to one and to the memory depth; num_buffers must be written only
// while the block is idle, which the block itself does not enforce.
module rx_ring_sequence_flow_control #(
  parameter int MAX_BUFFERS = rrsfc_pkg::MAX_BUFFERS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rrsfc_in_if.sink                     req_i,
  rrsfc_out_if.source                  rsp_o,
  input  logic                         cfg_we_i,
  input  logic [rrsfc_pkg::NBUF_W-1:0] cfg_wdata_i
);
  import rrsfc_pkg::*;

  localparam int Depth = (MAX_BUFFERS < RING_CAP) ? MAX_BUFFERS : RING_CAP;
  localparam logic [NBUF_W-1:0] RingMax = NBUF_W'(Depth);

  logic [NBUF_W-1:0] num_buffers_q;
  logic [NBUF_W-1:0] ring_len;
  logic [SLOT_W-1:0] next_slot_q, next_slot_d;
  logic [NBUF_W-1:0] pacing_q, pacing_d;

  logic              s_valid_q;
  logic              s_action_q;
  logic [SEQ_W-1:0]  s_header_q;
  logic [SLOT_W-1:0] s_slot_q;

  logic              r_valid_q;
  result_t           r_q;

  logic              accept;
  logic              s_fire;
  logic [SLOT_W-1:0] rd_slot;
  slot_entry_t       entry;
  result_t           result;
  update_t           update;

  // Ring length clamp.
  always_comb begin
    if (num_buffers_q == '0) begin
      ring_len = NBUF_W'(1);
    end else if (num_buffers_q > RingMax) begin
      ring_len = RingMax;
    end else begin
      ring_len = num_buffers_q;
    end
  end

  // Handshake: the stage moves on when the result register is free or drains.
  assign s_fire      = s_valid_q && (!r_valid_q || rsp_o.ready);
  assign req_i.ready = !s_valid_q || s_fire;
  assign accept      = req_i.valid && req_i.ready;

  // Pointer and pacing updates from the word in the stage.
  assign next_slot_d = (s_fire && update.advance) ? update.next_slot : next_slot_q;
  assign pacing_d    = (s_fire && update.pacing_upd) ? update.pacing_next : pacing_q;

  // Slot to read for the incoming word; a stale pointer beyond the ring polls slot zero.
  always_comb begin
    if (req_i.action == ACT_FREE) begin
      rd_slot = req_i.free_slot;
    end else if (NBUF_W'(next_slot_d) < ring_len) begin
      rd_slot = next_slot_d;
    end else begin
      rd_slot = '0;
    end
  end

  rrsfc_slot_mem #(
    .Depth (Depth)
  ) u_slot_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_slot_i  (rd_slot),
    .wr_en_i    (s_fire && update.wr_en),
    .wr_slot_i  (s_slot_q),
    .wr_entry_i (update.wr_entry),
    .rd_entry_o (entry)
  );

  rrsfc_step u_step (
    .action_i          (s_action_q),
    .header_sequence_i (s_header_q),
    .slot_i            (s_slot_q),
    .entry_i           (entry),
    .ring_len_i        (ring_len),
    .pacing_i          (pacing_q),
    .result_o          (result),
    .update_o          (update)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_buffers_q <= NBUF_RESET;
      next_slot_q   <= '0;
      pacing_q      <= '0;
      s_valid_q     <= 1'b0;
      r_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_buffers_q <= cfg_wdata_i;
      end
      next_slot_q <= next_slot_d;
      pacing_q    <= pacing_d;
      if (accept) begin
        s_valid_q <= 1'b1;
      end else if (s_fire) begin
        s_valid_q <= 1'b0;
      end
      if (s_fire) begin
        r_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        r_valid_q <= 1'b0;
      end
    end
  end

  // Stage and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_action_q <= req_i.action;
      s_header_q <= req_i.header_sequence;
      s_slot_q   <= rd_slot;
    end
    if (s_fire) begin
      r_q <= result;
    end
  end

  assign rsp_o.valid             = r_valid_q;
  assign rsp_o.new_message       = r_q.new_message;
  assign rsp_o.result_slot       = r_q.result_slot;
  assign rsp_o.sequence_error    = r_q.sequence_error;
  assign rsp_o.ownership_error   = r_q.ownership_error;
  assign rsp_o.freed_sequence    = r_q.freed_sequence;
  assign rsp_o.request_signaled  = r_q.request_signaled;
  assign rsp_o.wait_completion   = r_q.wait_completion;

endmodule

// ===== src/rrsfc_checker.sv =====
// Port-level checks for the receive ring tracker, bound to the top level.
module rrsfc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input logic                         new_message_i,
  input logic                         sequence_error_i,
  input logic                         ownership_error_i,
  input logic [rrsfc_pkg::SEQ_W-1:0]  freed_sequence_i,
  input logic                         request_signaled_i,
  input logic                         wait_completion_i
);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(freed_sequence_i)
      && $stable(ownership_error_i) && $stable(new_message_i))
    else $error("stalled result word changed");

  // A delivered message carries no error of either kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && new_message_i |-> !sequence_error_i && !ownership_error_i)
    else $error("message flagged together with an error");

  // A refused free returns no sequence and no pacing flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && ownership_error_i |->
      freed_sequence_i == '0 && !request_signaled_i && !wait_completion_i)
    else $error("refused free carries free data");

  // Waiting for a completion restarts the pacing window, which always signals.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && wait_completion_i |-> request_signaled_i)
    else $error("wait without a signaled request");

endmodule

bind rx_ring_sequence_flow_control rrsfc_checker u_rrsfc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .new_message_i       (rsp_o.new_message),
  .sequence_error_i    (rsp_o.sequence_error),
  .ownership_error_i   (rsp_o.ownership_error),
  .freed_sequence_i    (rsp_o.freed_sequence),
  .request_signaled_i  (rsp_o.request_signaled),
  .wait_completion_i   (rsp_o.wait_completion)
);
